/* rtl/wsd_pkg.sv */
`timescale 1ns / 1ps

package wsd_pkg;

  // Parser phases of the frame header and payload
  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXTH = 3'd2,
    PH_EXTL = 3'd3,
    PH_MASK = 3'd4,
    PH_DATA = 3'd5,
    PH_ERRP = 3'd6
  } phase_e;

  // Result event codes
  typedef enum logic [2:0] {
    EV_DATA    = 3'd0,
    EV_PING    = 3'd1,
    EV_DEND    = 3'd2,
    EV_EPING   = 3'd3,
    EV_CLOSE   = 3'd4,
    EV_LONGLEN = 3'd5,
    EV_TOOLONG = 3'd6,
    EV_CTLRUN  = 3'd7
  } event_e;

  // Frame opcodes with special handling
  localparam logic [3:0] OPC_CLOSE = 4'd8;
  localparam logic [3:0] OPC_PING  = 4'd9;
  localparam logic [3:0] OPC_PONG  = 4'd10;

  // Length field codes
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // Control run counter saturation
  localparam logic [3:0] CTL_RUN_SAT = 4'd15;

  // Configuration register indexes
  localparam logic [1:0] CFG_MAX_FRAME = 2'd0;
  localparam logic [1:0] CFG_MAX_DATA  = 2'd1;
  localparam logic [1:0] CFG_MAX_CTL   = 2'd2;

  localparam logic [15:0] MAX_FRAME_RST = 16'd4096;
  localparam logic [15:0] MAX_DATA_RST  = 16'd4096;
  localparam logic [3:0]  MAX_CTL_RST   = 4'd8;

  // Queue between parser and result stage
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  // One classified item for the result stage
  typedef struct packed {
    event_e     ev;
    logic [7:0] data;
    logic [7:0] key;
    logic [3:0] opcode;
    logic       last;
  } cmd_t;

endpackage

/* rtl/wsd_front.sv */
`timescale 1ns / 1ps

module wsd_front import wsd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  output logic        cmd_push_o,
  output cmd_t        cmd_o
);

  phase_e      phase_q, phase_d;
  logic [3:0]  opc_q, opc_d;
  logic        masked_q, masked_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  exth_q, exth_d;
  logic [31:0] key_q, key_d;
  logic [15:0] idx_q, idx_d;
  logic [3:0]  run_q, run_d;
  logic        halted_q, halted_d;

  logic [15:0] max_frame_q;
  logic [15:0] max_data_q;
  logic [3:0]  max_ctl_q;

  logic        emit;
  event_e      ev;
  logic        last;
  logic        byte_ev;

  logic        after_req;
  logic        after_masked;
  logic [15:0] after_len;
  logic        begin_req;
  logic [15:0] begin_len;
  logic        end_req;
  logic        end_had;
  logic        end_zero;
  logic        fin;
  logic [16:0] idx_inc;
  logic [7:0]  key_byte;

  assign idx_inc  = {1'b0, idx_q} + 17'd1;
  assign fin      = idx_inc >= {1'b0, len_q};
  assign key_byte = masked_q ? key_q[{idx_q[1:0], 3'b000} +: 8] : 8'h00;

  // Next state of the parser and the event decision
  always_comb begin
    logic       had;
    logic [3:0] run_nx;
    phase_d      = phase_q;
    opc_d        = opc_q;
    masked_d     = masked_q;
    len_d        = len_q;
    exth_d       = exth_q;
    key_d        = key_q;
    idx_d        = idx_q;
    run_d        = run_q;
    halted_d     = halted_q;
    emit         = 1'b0;
    ev           = EV_DATA;
    last         = 1'b0;
    after_req    = 1'b0;
    after_masked = 1'b0;
    after_len    = '0;
    begin_req    = 1'b0;
    begin_len    = '0;
    end_req      = 1'b0;
    end_had      = 1'b0;
    end_zero     = 1'b0;
    had          = 1'b0;
    run_nx       = run_q;

    if (accept_i && !halted_q) begin
      unique case (phase_q)
        PH_HDR0: begin
          opc_d   = rx_byte_i[3:0];
          phase_d = PH_HDR1;
        end
        PH_HDR1: begin
          masked_d = rx_byte_i[7];
          if (rx_byte_i[6:0] == LEN_EXT64) begin
            emit     = 1'b1;
            ev       = EV_LONGLEN;
            last     = 1'b1;
            halted_d = 1'b1;
          end else if (rx_byte_i[6:0] == LEN_EXT16) begin
            phase_d = PH_EXTH;
          end else begin
            len_d        = {9'd0, rx_byte_i[6:0]};
            after_req    = 1'b1;
            after_masked = rx_byte_i[7];
            after_len    = {9'd0, rx_byte_i[6:0]};
          end
        end
        PH_EXTH: begin
          exth_d  = rx_byte_i;
          phase_d = PH_EXTL;
        end
        PH_EXTL: begin
          len_d        = {exth_q, rx_byte_i};
          after_req    = 1'b1;
          after_masked = masked_q;
          after_len    = {exth_q, rx_byte_i};
        end
        PH_MASK: begin
          key_d[{idx_q[1:0], 3'b000} +: 8] = rx_byte_i;
          idx_d = idx_inc[15:0];
          if (idx_q[1:0] == 2'd3) begin
            begin_req = 1'b1;
            begin_len = len_q;
          end
        end
        PH_DATA: begin
          idx_d = idx_inc[15:0];
          if (opc_q == OPC_PING) begin
            emit = 1'b1;
            ev   = EV_PING;
            last = fin;
          end else if (opc_q != OPC_PONG && opc_q != OPC_CLOSE) begin
            if (idx_q < max_data_q) begin
              emit = 1'b1;
              ev   = EV_DATA;
              last = fin;
            end else if (fin) begin
              emit = 1'b1;
              ev   = EV_DEND;
              last = 1'b1;
            end
          end
          if (fin) begin
            end_req = 1'b1;
            end_had = emit;
          end
        end
        PH_ERRP: begin
          emit     = 1'b1;
          ev       = EV_CTLRUN;
          last     = 1'b1;
          halted_d = 1'b1;
        end
        default: begin
          phase_d = PH_HDR0;
        end
      endcase
    end

    // Length known: fetch the mask key or go on to the payload
    if (after_req) begin
      if (after_masked) begin
        phase_d = PH_MASK;
        idx_d   = '0;
        key_d   = '0;
      end else begin
        begin_req = 1'b1;
        begin_len = after_len;
      end
    end

    // Header done: check the length, then start or finish the payload
    if (begin_req) begin
      if (begin_len > max_frame_q) begin
        emit     = 1'b1;
        ev       = EV_TOOLONG;
        last     = 1'b1;
        halted_d = 1'b1;
      end else if (begin_len == 16'd0) begin
        end_req  = 1'b1;
        end_zero = 1'b1;
      end else begin
        phase_d = PH_DATA;
        idx_d   = '0;
      end
    end

    // Frame complete: close, control run bookkeeping, data end
    if (end_req) begin
      phase_d = PH_HDR0;
      idx_d   = '0;
      had     = end_had;
      if (opc_q == OPC_CLOSE) begin
        emit     = 1'b1;
        ev       = EV_CLOSE;
        last     = 1'b1;
        halted_d = 1'b1;
      end else if (opc_q == OPC_PING || opc_q == OPC_PONG) begin
        if (!had && opc_q == OPC_PING && end_zero) begin
          emit = 1'b1;
          ev   = EV_EPING;
          last = 1'b1;
          had  = 1'b1;
        end
        run_nx = (run_q < CTL_RUN_SAT) ? run_q + 4'd1 : run_q;
        run_d  = run_nx;
        if (run_nx >= max_ctl_q) begin
          if (had) begin
            phase_d = PH_ERRP;
          end else begin
            emit     = 1'b1;
            ev       = EV_CTLRUN;
            last     = 1'b1;
            halted_d = 1'b1;
          end
        end
      end else begin
        run_d = '0;
        if (!had) begin
          emit = 1'b1;
          ev   = EV_DEND;
          last = 1'b1;
        end
      end
    end
  end

  // Build the item for the result stage
  always_comb begin
    byte_ev       = (ev == EV_DATA) || (ev == EV_PING);
    cmd_push_o    = emit;
    cmd_o.ev      = ev;
    cmd_o.data    = byte_ev ? rx_byte_i : 8'h00;
    cmd_o.key     = byte_ev ? key_byte : 8'h00;
    cmd_o.opcode  = opc_q;
    cmd_o.last    = last;
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR0;
      opc_q    <= '0;
      masked_q <= 1'b0;
      len_q    <= '0;
      exth_q   <= '0;
      key_q    <= '0;
      idx_q    <= '0;
      run_q    <= '0;
      halted_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      opc_q    <= opc_d;
      masked_q <= masked_d;
      len_q    <= len_d;
      exth_q   <= exth_d;
      key_q    <= key_d;
      idx_q    <= idx_d;
      run_q    <= run_d;
      halted_q <= halted_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_frame_q <= MAX_FRAME_RST;
      max_data_q  <= MAX_DATA_RST;
      max_ctl_q   <= MAX_CTL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAX_FRAME: max_frame_q <= cfg_data_i;
        CFG_MAX_DATA:  max_data_q  <= cfg_data_i;
        CFG_MAX_CTL:   max_ctl_q   <= cfg_data_i[3:0];
        default: begin
        end
      endcase
    end
  end

  // Close and errors stop the parser for good
  a_halt_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halt flag cleared without reset");

  a_no_item_halted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> !cmd_push_o)
    else $error("item produced while halted");

  a_event_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_push_o && cmd_o.ev != EV_DATA && cmd_o.ev != EV_PING) |-> cmd_o.last)
    else $error("frame-level event without last");

endmodule

/* rtl/wsd_queue.sv */
`timescale 1ns / 1ps

module wsd_queue import wsd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  cmd_t  cmd_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output cmd_t  cmd_o
);

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push;
  logic              do_pop;

  assign full_o  = cnt_q == QCNT_W'(QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Store the item at the tail
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

/* rtl/wsd_back.sv */
`timescale 1ns / 1ps

module wsd_back import wsd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  cmd_t       q_cmd_i,
  output logic       q_pop_o,
  output logic       empty_o,
  input  logic       pop_i,
  output logic [2:0] event_res_o,
  output logic [7:0] payload_byte_o,
  output logic [3:0] frame_opcode_o,
  output logic       last_o
);

  logic       out_valid_q;
  logic [2:0] ev_q;
  logic [7:0] byte_q;
  logic [3:0] opc_q;
  logic       last_q;
  logic       take;

  // Take a new item when the output slot is free or being drained
  assign take    = q_valid_i && (!out_valid_q || pop_i);
  assign q_pop_o = take;
  assign empty_o = !out_valid_q;

  assign event_res_o    = ev_q;
  assign payload_byte_o = byte_q;
  assign frame_opcode_o = opc_q;
  assign last_o         = last_q;

  // Hold the output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Unmask the payload byte and register the result
  always_ff @(posedge clk_i) begin
    if (take) begin
      ev_q   <= q_cmd_i.ev;
      byte_q <= q_cmd_i.data ^ q_cmd_i.key;
      opc_q  <= q_cmd_i.opcode;
      last_q <= q_cmd_i.last;
    end
  end

  a_no_take_unqueued : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> q_valid_i)
    else $error("result stage took from an empty queue");

endmodule

/* rtl/websocket_frame_deframer.sv */
`timescale 1ns / 1ps

// Receive-side frame parser: takes one received byte per cycle, at full rate,
// as long as the result side keeps up. The header/payload parser classifies
// each accepted byte in the accepting cycle into a two-entry queue, and the
// unmask stage then moves its result (if any) from that queue into the
// output register on the result ports; the queue lets either side stall
// alone. full rises only when that queue holds two pending results. After
// a close event or any error the block takes bytes and drops them until reset.
module websocket_frame_deframer import wsd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  event_res_o,
  output logic [7:0]  payload_byte_o,
  output logic [3:0]  frame_opcode_o,
  output logic        last_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  logic accept;
  logic cmd_push;
  cmd_t cmd_in;
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  assign accept = push && !full;

  // Parse and classify bytes
  wsd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .rx_byte_i  (rx_byte_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  // Decouple parser and result stage
  wsd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  // Unmask and present results
  wsd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_cmd_i        (q_cmd),
    .q_pop_o        (q_pop),
    .empty_o        (empty),
    .pop_i          (pop),
    .event_res_o    (event_res_o),
    .payload_byte_o (payload_byte_o),
    .frame_opcode_o (frame_opcode_o),
    .last_o         (last_o)
  );

endmodule
